@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the union-find edge filter RTL.
// Both macros compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define KUFEF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kufef assertion failed");

// Condition must never be true outside reset
`define KUFEF_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("kufef forbidden condition seen");

`else

`define KUFEF_ASSERT(name, clk, rst_n, prop)
`define KUFEF_NEVER(name, clk, rst_n, cond)

`endif

`endif

@@ src/kufef_pkg.sv @@
// ----------------------------------------------------------------------------
// kufef_pkg
// Shared item types and fixed constants of the union-find edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kufef_pkg;

  // Fixed field widths
  localparam int VIDX_W  = 7;   // vertex index on the input item
  localparam int WIN_W   = 16;  // edge weight on the input item
  localparam int SUM_W   = 23;  // total weight on the result item
  localparam int COUNT_W = 8;   // internal accepted-edge counter
  localparam int RANK_W  = 3;   // rank stored per forest entry
  localparam int VCNT_W  = 8;   // vertex_count register

  localparam logic [RANK_W-1:0]  RANK_MAX     = 3'd7;
  localparam logic [SUM_W-1:0]   SUM_MAX      = 23'h7F_FFFF;
  localparam logic [COUNT_W-1:0] TREE_OUT_MAX = 8'd127;
  localparam logic [VCNT_W-1:0]  VCOUNT_RESET = 8'd7;

  // One edge item
  typedef struct packed {
    logic              first_edge;
    logic [VIDX_W-1:0] src_vertex;
    logic [VIDX_W-1:0] dest_vertex;
    logic [WIN_W-1:0]  edge_weight;
  } edge_t;

  // One result item
  typedef struct packed {
    logic              accepted;
    logic              bad_vertex;
    logic [VIDX_W-1:0] tree_edges;
    logic [SUM_W-1:0]  total_weight;
    logic              complete;
  } result_t;

endpackage

`default_nettype wire

@@ src/kufef_chan_if.sv @@
// ----------------------------------------------------------------------------
// kufef_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface kufef_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/kufef_forest_mem.sv @@
// ----------------------------------------------------------------------------
// kufef_forest_mem
// Forest store: one entry per vertex holding {rank, parent}. One write port,
// one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kufef_forest_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/kufef_engine.sv @@
// ----------------------------------------------------------------------------
// kufef_engine
// Sequencer for one edge: clearing sweep, two root finds with path
// compression, union by rank, and the count / weight bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module kufef_engine
  import kufef_pkg::*;
#(
  parameter int MAX_VERTICES = 128,
  parameter int WEIGHT_BITS  = 16,
  parameter int VW           = 7,
  parameter int EW           = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // edge items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  edge_t             in_item_i,
  // configuration
  input  logic [VCNT_W-1:0] vertex_count_i,
  // result items
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_item_o,
  // forest memory
  output logic              mem_we_o,
  output logic [VW-1:0]     mem_waddr_o,
  output logic [EW-1:0]     mem_wdata_o,
  output logic [VW-1:0]     mem_raddr_o,
  input  logic [EW-1:0]     mem_rdata_i
);

  localparam int WSTORE = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
  localparam int NV_CAP = (MAX_VERTICES > 255) ? 255 : MAX_VERTICES;
  localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_FIND  = 8'b0000_1000,
    S_COMP  = 8'b0001_0000,
    S_JOIN  = 8'b0010_0000,
    S_RANK  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic [VW-1:0]      clr_q, clr_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               acc_q, acc_d;
  logic               bad_q, bad_d;

  logic [VIDX_W-1:0] src_q, src_d, dst_q, dst_d;
  logic [WSTORE-1:0] wt_q, wt_d;
  logic [VW-1:0]     cur_q, cur_d, root_q, root_d, rs_q, rs_d;
  logic              phase_q, phase_d;
  logic [RANK_W-1:0] rank_s_q, rank_s_d, rank_d_q, rank_d_d;

  logic [VCNT_W-1:0] nv, target;
  logic [VW-1:0]     src_v, dst_v, start_v;
  logic [VW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic [SUM_W:0]    sum_ext;

  // Effective vertex count and spanning-tree edge target
  assign nv     = (vertex_count_i > VCNT_W'(NV_CAP)) ? VCNT_W'(NV_CAP) : vertex_count_i;
  assign target = (nv == '0) ? '0 : nv - VCNT_W'(1);

  assign src_v     = VW'(src_q);
  assign dst_v     = VW'(dst_q);
  assign start_v   = phase_q ? dst_v : src_v;
  assign rd_parent = mem_rdata_i[VW-1:0];
  assign rd_rank   = mem_rdata_i[EW-1:VW];
  assign sum_ext   = {1'b0, sum_q} + (SUM_W+1)'(wt_q);

  // Next-state and memory access logic
  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    clr_d    = clr_q;
    count_d  = count_q;
    sum_d    = sum_q;
    acc_d    = acc_q;
    bad_d    = bad_q;
    src_d    = src_q;
    dst_d    = dst_q;
    wt_d     = wt_q;
    cur_d    = cur_q;
    root_d   = root_q;
    rs_d     = rs_q;
    phase_d  = phase_q;
    rank_s_d = rank_s_q;
    rank_d_d = rank_d_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = '0;
    mem_raddr_o = cur_q;

    case (state_q)
      // one entry per cycle back to a singleton tree
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = {{RANK_W{1'b0}}, clr_q};
        clr_d       = clr_q + VW'(1);
        if (clr_q == LAST_IDX) begin
          clr_d   = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? S_CHECK : S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          src_d = in_item_i.src_vertex;
          dst_d = in_item_i.dest_vertex;
          wt_d  = in_item_i.edge_weight[WSTORE-1:0];
          acc_d = 1'b0;
          bad_d = 1'b0;
          if (in_item_i.first_edge) begin
            count_d = '0;
            sum_d   = '0;
            pend_d  = 1'b1;
            state_d = S_CLEAR;
          end else begin
            state_d = S_CHECK;
          end
        end
      end

      // range and tree-full checks, then start the source find
      S_CHECK: begin
        if (({1'b0, src_q} >= nv) || ({1'b0, dst_q} >= nv)) begin
          bad_d   = 1'b1;
          state_d = S_DONE;
        end else if (count_q < target) begin
          mem_raddr_o = src_v;
          cur_d       = src_v;
          phase_d     = 1'b0;
          state_d     = S_FIND;
        end else begin
          state_d = S_DONE;
        end
      end

      // walk parent pointers, one hop per cycle
      S_FIND: begin
        if (rd_parent == cur_q) begin
          root_d = cur_q;
          if (phase_q) begin
            rank_d_d = rd_rank;
          end else begin
            rank_s_d = rd_rank;
          end
          mem_raddr_o = start_v;
          cur_d       = start_v;
          state_d     = S_COMP;
        end else begin
          mem_raddr_o = rd_parent;
          cur_d       = rd_parent;
        end
      end

      // rewalk the path, pointing each node at the root
      S_COMP: begin
        if (cur_q == root_q) begin
          if (!phase_q) begin
            rs_d        = root_q;
            mem_raddr_o = dst_v;
            cur_d       = dst_v;
            phase_d     = 1'b1;
            state_d     = S_FIND;
          end else if (root_q == rs_q) begin
            state_d = S_DONE;
          end else begin
            acc_d   = 1'b1;
            count_d = count_q + COUNT_W'(1);
            sum_d   = (sum_ext > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
            state_d = S_JOIN;
          end
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q;
          mem_wdata_o = {rd_rank, root_q};
          mem_raddr_o = rd_parent;
          cur_d       = rd_parent;
        end
      end

      // union by rank: hang the lower tree under the higher one
      S_JOIN: begin
        mem_we_o = 1'b1;
        state_d  = S_DONE;
        if (rank_s_q < rank_d_q) begin
          mem_waddr_o = rs_q;
          mem_wdata_o = {rank_s_q, root_q};
        end else begin
          mem_waddr_o = root_q;
          mem_wdata_o = {rank_d_q, rs_q};
          if ((rank_s_q == rank_d_q) && (rank_s_q < RANK_MAX)) begin
            state_d = S_RANK;
          end
        end
      end

      // equal ranks: the surviving root grows by one
      S_RANK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = rs_q;
        mem_wdata_o = {rank_s_q + RANK_W'(1), rs_q};
        state_d     = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result item
  always_comb begin
    res_item_o.accepted     = acc_q;
    res_item_o.bad_vertex   = bad_q;
    res_item_o.tree_edges   = (count_q > TREE_OUT_MAX) ? TREE_OUT_MAX[VIDX_W-1:0]
                                                       : count_q[VIDX_W-1:0];
    res_item_o.total_weight = sum_q;
    res_item_o.complete     = (count_q >= target);
  end

  // Control state; reset starts a clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
      clr_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
      acc_q   <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    wt_q     <= wt_d;
    cur_q    <= cur_d;
    root_q   <= root_d;
    rs_q     <= rs_d;
    phase_q  <= phase_d;
    rank_s_q <= rank_s_d;
    rank_d_q <= rank_d_d;
  end

endmodule

`default_nettype wire

@@ src/kruskal_union_find_edge_filter.sv @@
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Kruskal spanning-tree edge filter over a union-find forest in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   edge_i carries one edge item (first_edge, src_vertex, dest_vertex,
//   edge_weight); edges are sent in non-decreasing weight order. result_o
//   returns exactly one result item per edge, in order. cfg_i writes
//   vertex_count; it is always ready and should be written only while idle.
//   The work for an edge grows with ds and dd, the endpoint depths below their
//   roots (at most log2 of the vertex count with union by rank); a taken edge
//   adds a join write and equal ranks a rank write. A bad endpoint or a
//   finished tree goes straight from the check to its result. One edge is in
//   flight at a time; the next is taken only once the engine is back in idle
//   after handing on the result. The single read port of the forest memory,
//   one hop per cycle, sets the rate.
//   An edge with first_edge set first sweeps all MAX_VERTICES forest entries.
//   After reset the same sweep runs while edge_i is not ready; cfg_i writes
//   are taken throughout.
//   A result waits in an output register; when the receiver stalls the next
//   edge is still taken and worked, and holds only at its own result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kruskal_union_find_edge_filter
  import kufef_pkg::*;
#(
  parameter int MAX_VERTICES = 128,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kufef_chan_if.sink   edge_i,
  kufef_chan_if.source result_o,
  kufef_chan_if.sink   cfg_i
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = RANK_W + VW;

  logic [VCNT_W-1:0] vcount_q;
  logic              res_valid, res_ready;
  result_t           res_item;
  logic              out_valid_q;
  result_t           out_item_q;
  logic              mem_we;
  logic [VW-1:0]     mem_waddr, mem_raddr;
  logic [EW-1:0]     mem_wdata, mem_rdata;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_i.valid) begin
      vcount_q <= cfg_i.data;
    end
  end

  // Edge sequencer
  kufef_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .VW           (VW),
    .EW           (EW)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (edge_i.valid),
    .in_ready_o     (edge_i.ready),
    .in_item_i      (edge_i.data),
    .vertex_count_i (vcount_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_item_o     (res_item),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Forest store
  kufef_forest_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (VW),
    .DW    (EW)
  ) u_forest (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res_item;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

  // Checks
  `KUFEF_ASSERT(a_busy_after_accept, clk_i, rst_ni, edge_i.valid && edge_i.ready |=> !edge_i.ready)
  `KUFEF_NEVER(a_no_write_while_idle, clk_i, rst_ni, edge_i.ready && mem_we)
  `KUFEF_ASSERT(a_accept_is_sane, clk_i, rst_ni, result_o.valid && result_o.data.accepted |-> !result_o.data.bad_vertex && result_o.data.tree_edges != '0)

endmodule

`default_nettype wire

@@ bench/kruskal_union_find_edge_filter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_tb
// Self-checking bench for the spanning-tree edge filter. Edge items are fed
// from a queue by a clocked driver. A union-find predictor with union by rank
// and path compression computes each expected result as the edge is taken.
// A clocked monitor compares every result field by field. The run walks
// through many vertex counts and uses random gaps on both sides, a long
// result stall and full drains between graphs.
// ----------------------------------------------------------------------------

module kruskal_union_find_edge_filter_tb;
  import kufef_pkg::*;

  localparam int          NUM_VERTICES = 128;
  localparam int          WEIGHT_BITS  = 16;
  localparam int          CLK_PERIOD   = 20;
  localparam int          ITEM_BUDGET  = 1200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst_n;

  kufef_chan_if #(.T(edge_t))              edge_ch ();
  kufef_chan_if #(.T(result_t))            result_ch ();
  kufef_chan_if #(.T(logic [VCNT_W-1:0]))  cfg_ch ();

  kruskal_union_find_edge_filter #(
    .MAX_VERTICES(NUM_VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .edge_i  (edge_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: forest, tree size, weight total, vertex count
  logic [VIDX_W-1:0] forest_parent [NUM_VERTICES];
  logic [RANK_W-1:0] forest_rank   [NUM_VERTICES];
  int unsigned       tree_count;
  logic [SUM_W-1:0]  weight_total;
  logic [VCNT_W-1:0] vertex_limit;

  edge_t   pending_edges[$];
  result_t expected_results[$];

  // Handshake flags, set at the rising edge and read at the falling edge
  bit edge_taken;
  bit result_taken;

  int unsigned edge_gap_max = 8;
  int unsigned res_gap_max  = 8;
  int unsigned edge_wait;
  int unsigned res_wait;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  int unsigned edges_queued;
  int unsigned edges_sent;
  int unsigned results_checked;
  int unsigned accepted_seen;
  int unsigned bad_seen;
  int unsigned trees_closed;
  int unsigned phase_count;
  int unsigned fail_count;
  int unsigned cycle_count;

  function automatic void clear_forest();
    for (int v = 0; v < NUM_VERTICES; v++) begin
      forest_parent[v] = v[VIDX_W-1:0];
      forest_rank[v]   = '0;
    end
    tree_count   = 0;
    weight_total = '0;
  endfunction

  // Root lookup; every node on the walk is pointed straight at the root
  function automatic logic [VIDX_W-1:0] find_root(input logic [VIDX_W-1:0] v);
    logic [VIDX_W-1:0] r;
    logic [VIDX_W-1:0] nxt;
    int                hops;
    r = v;
    for (hops = 0; hops < NUM_VERTICES && forest_parent[r] != r; hops++)
      r = forest_parent[r];
    for (hops = 0; hops < NUM_VERTICES && v != r; hops++) begin
      nxt              = forest_parent[v];
      forest_parent[v] = r;
      v                = nxt;
    end
    return r;
  endfunction

  // One edge through the filter: updates the forest, returns the result item
  function automatic result_t filter_edge(input edge_t e);
    result_t           r;
    int unsigned       nv;
    int unsigned       target;
    int unsigned       s;
    logic [VIDX_W-1:0] rs;
    logic [VIDX_W-1:0] rd;
    nv     = (vertex_limit > NUM_VERTICES) ? NUM_VERTICES : vertex_limit;
    target = (nv > 0) ? nv - 1 : 0;
    if (e.first_edge)
      clear_forest();
    r = '0;
    if (e.src_vertex >= nv || e.dest_vertex >= nv) begin
      r.bad_vertex = 1'b1;
    end else if (tree_count < target) begin
      rs = find_root(e.src_vertex);
      rd = find_root(e.dest_vertex);
      if (rs != rd) begin
        r.accepted = 1'b1;
        tree_count++;
        s = weight_total + e.edge_weight;
        weight_total = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
        // union by rank, rank saturates
        if (forest_rank[rs] < forest_rank[rd]) begin
          forest_parent[rs] = rd;
        end else if (forest_rank[rs] > forest_rank[rd]) begin
          forest_parent[rd] = rs;
        end else begin
          forest_parent[rd] = rs;
          if (forest_rank[rs] != RANK_MAX)
            forest_rank[rs]++;
        end
      end
    end
    r.tree_edges   = (tree_count > TREE_OUT_MAX) ? TREE_OUT_MAX[VIDX_W-1:0]
                                                 : tree_count[VIDX_W-1:0];
    r.total_weight = weight_total;
    r.complete     = (tree_count >= target);
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // Edge side: predict on every accepted item
  always @(posedge clk) begin
    edge_taken = rst_n && edge_ch.valid && edge_ch.ready;
    if (edge_taken) begin
      expected_results.push_back(filter_edge(edge_ch.data));
      edges_sent++;
    end
  end

  // Result side: compare against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    result_t got;
    result_taken = rst_n && result_ch.valid && result_ch.ready;
    if (result_taken) begin
      got = result_ch.data;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result acc=%0b bad=%0b edges=%0d total=%0d cmp=%0b",
                               got.accepted, got.bad_vertex, got.tree_edges,
                               got.total_weight, got.complete));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.accepted !== want.accepted || got.bad_vertex !== want.bad_vertex ||
            got.tree_edges !== want.tree_edges ||
            got.total_weight !== want.total_weight || got.complete !== want.complete) begin
          note_failure($sformatf({"result %0d: exp acc=%0b bad=%0b edges=%0d total=%0d ",
                                  "cmp=%0b, got acc=%0b bad=%0b edges=%0d total=%0d cmp=%0b"},
                                 results_checked, want.accepted, want.bad_vertex,
                                 want.tree_edges, want.total_weight, want.complete,
                                 got.accepted, got.bad_vertex, got.tree_edges,
                                 got.total_weight, got.complete));
        end
        if (want.accepted)
          accepted_seen++;
        if (want.bad_vertex)
          bad_seen++;
        if (want.accepted && want.complete)
          trees_closed++;
      end
    end
  end

  // Driver: present queued edges with a random gap after each item
  always @(negedge clk) begin
    if (edge_ch.valid && !edge_taken) begin
      // item still waiting for ready
    end else if (edge_wait != 0) begin
      edge_wait--;
      edge_ch.valid <= 1'b0;
    end else if (pending_edges.size() != 0) begin
      edge_ch.data  <= pending_edges.pop_front();
      edge_ch.valid <= 1'b1;
      edge_wait     = $urandom_range(0, edge_gap_max);
    end else begin
      edge_ch.valid <= 1'b0;
    end
  end

  // Receiver: random stall after each item, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (result_taken)
      res_wait = $urandom_range(0, res_gap_max);
    if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (res_wait != 0) begin
      res_wait--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout: %0d edges sent, %0d results outstanding",
               edges_sent, expected_results.size());
      $display("** kruskal_union_find_edge_filter: FAILED **");
      $finish;
    end
  end

  task automatic queue_edge(input bit first, input int unsigned src, input int unsigned dst,
                            input int unsigned weight);
    edge_t e;
    e.first_edge  = first;
    e.src_vertex  = src[VIDX_W-1:0];
    e.dest_vertex = dst[VIDX_W-1:0];
    e.edge_weight = weight[WIN_W-1:0];
    pending_edges.push_back(e);
    edges_queued++;
  endtask

  // Block is idle once every queued edge has been sent and answered
  task automatic wait_idle();
    while (pending_edges.size() != 0 || edge_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VCNT_W-1:0] value);
    @(negedge clk);
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    vertex_limit = value;
    phase_count++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One graph of nv vertices: a random spanning tree mixed with extra edges,
  // or a perfectly balanced merge order that drives ranks to the top.
  // Weights rise, with stray bad endpoints, self loops, resets and
  // out-of-order weights sprinkled in.
  task automatic queue_graph(input int unsigned nv, input bit fresh, input bit balanced);
    edge_t             pairs[$];
    edge_t             e;
    edge_t             t;
    logic [VIDX_W-1:0] label [NUM_VERTICES];
    logic [VIDX_W-1:0] tmp;
    int unsigned       i;
    int unsigned       j;
    int unsigned       span;
    int unsigned       wt;
    for (i = 0; i < NUM_VERTICES; i++)
      label[i] = i[VIDX_W-1:0];
    for (i = nv; i > 1; i--) begin
      j          = $urandom_range(0, i - 1);
      tmp        = label[i-1];
      label[i-1] = label[j];
      label[j]   = tmp;
    end
    e = '0;
    if (nv < 2) begin
      repeat ($urandom_range(4, 10)) begin
        e.src_vertex  = VIDX_W'($urandom_range(0, 3));
        e.dest_vertex = VIDX_W'($urandom_range(0, 3));
        pairs.push_back(e);
      end
    end else if (balanced) begin
      for (span = 1; span < nv; span = span * 2)
        for (i = 0; i + span < nv; i = i + 2 * span) begin
          e.src_vertex  = label[i];
          e.dest_vertex = label[i+span];
          pairs.push_back(e);
        end
    end else begin
      for (i = 1; i < nv; i++) begin
        e.src_vertex  = label[i];
        e.dest_vertex = label[$urandom_range(0, i - 1)];
        if ($urandom_range(0, 1)) begin
          tmp           = e.src_vertex;
          e.src_vertex  = e.dest_vertex;
          e.dest_vertex = tmp;
        end
        pairs.push_back(e);
      end
      repeat ($urandom_range(0, nv)) begin
        e.src_vertex  = VIDX_W'($urandom_range(0, nv - 1));
        e.dest_vertex = VIDX_W'($urandom_range(0, nv - 1));
        pairs.push_back(e);
      end
      for (i = pairs.size(); i > 1; i--) begin
        j          = $urandom_range(0, i - 1);
        t          = pairs[i-1];
        pairs[i-1] = pairs[j];
        pairs[j]   = t;
      end
    end

    wt = ($urandom_range(0, 3) == 0) ? $urandom_range(60000, 65535) : $urandom_range(0, 1000);
    foreach (pairs[k]) begin
      // out-of-range endpoint on either side
      if (nv < NUM_VERTICES && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1))
          queue_edge(1'b0, $urandom_range(nv, NUM_VERTICES - 1), $urandom(), wt);
        else
          queue_edge(1'b0, $urandom(), $urandom_range(nv, NUM_VERTICES - 1), wt);
      end
      // self loop anywhere in the index range
      if ($urandom_range(0, 29) == 0) begin
        j = $urandom_range(0, NUM_VERTICES - 1);
        queue_edge(1'b0, j, j, wt);
      end
      wt = wt + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 8000) : $urandom_range(0, 300));
      if (wt > 65535)
        wt = 65535;
      queue_edge((k == 0) ? fresh : ($urandom_range(0, 79) == 0),
                 pairs[k].src_vertex, pairs[k].dest_vertex,
                 ($urandom_range(0, 29) == 0) ? $urandom_range(0, 65535) : wt);
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [VCNT_W-1:0] vc;
    int unsigned       nv;
    int unsigned       prev_nv;
    int unsigned       phase;
    bit                fresh;
    rst_n           = 1'b0;
    edge_ch.valid   = 1'b0;
    edge_ch.data    = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    clear_forest();
    vertex_limit = VCOUNT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: seven vertices, cycles, self loop, bad ends, completion
    write_vertex_count(8'd7);
    queue_edge(1'b1, 0, 1, 0);
    queue_edge(1'b0, 2, 2, 5);
    queue_edge(1'b0, 1, 0, 9);
    queue_edge(1'b0, 7, 0, 10);
    queue_edge(1'b0, 3, 127, 11);
    queue_edge(1'b0, 6, 5, 100);
    queue_edge(1'b0, 2, 3, 200);
    queue_edge(1'b0, 3, 4, 300);
    queue_edge(1'b0, 4, 0, 400);
    queue_edge(1'b0, 5, 2, 65535);
    queue_edge(1'b0, 0, 6, 65535);
    queue_edge(1'b0, 127, 1, 65535);
    queue_edge(1'b1, 127, 127, 0);
    queue_edge(1'b0, 1, 0, 65535);
    wait_idle();

    // Degenerate counts: nothing valid, then target of zero
    write_vertex_count(8'd0);
    queue_edge(1'b1, 0, 0, 0);
    wait_idle();
    write_vertex_count(8'd1);
    queue_edge(1'b1, 0, 0, 16'h5555);
    wait_idle();
    write_vertex_count(8'd2);
    queue_edge(1'b1, 1, 0, 16'hAAAA);
    wait_idle();

    // Count above the maximum, then changed in mid graph
    write_vertex_count(8'd255);
    queue_edge(1'b1, 127, 0, 1);
    queue_edge(1'b0, 0, 127, 2);
    wait_idle();
    write_vertex_count(8'd128);
    queue_edge(1'b0, 64, 127, 3);
    queue_edge(1'b0, 127, 64, 4);
    wait_idle();

    // Random graphs
    phase   = 0;
    prev_nv = 0;
    while (edges_queued < ITEM_BUDGET) begin
      case ($urandom_range(0, 31))
        0:          vc = 8'd0;
        1:          vc = 8'd1;
        2:          vc = 8'd2;
        3:          vc = 8'd128;
        4:          vc = 8'd255;
        5:          vc = VCNT_W'($urandom_range(129, 254));
        6, 7, 8, 9: vc = VCNT_W'($urandom_range(17, 40));
        default:    vc = VCNT_W'($urandom_range(3, 16));
      endcase
      if (phase == 0)
        vc = 8'd128;
      else if (phase == 1)
        vc = VCNT_W'($urandom_range(24, 40));
      nv    = (vc > NUM_VERTICES) ? NUM_VERTICES : vc;
      fresh = !(prev_nv >= 2 && $urandom_range(0, 4) == 0);
      edge_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      res_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 8;
      write_vertex_count(vc);
      // long receiver stall against a sender with no gaps
      if (phase == 1 || $urandom_range(0, 9) == 0) begin
        edge_gap_max = 0;
        hold_req++;
      end
      queue_graph(nv, fresh, phase == 0);
      wait_idle();
      prev_nv = nv;
      phase++;
    end

    repeat (200) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Run covered %0d edges in %0d vertex-count phases: %0d accepted, %0d bad ends,",
             edges_sent, phase_count, accepted_seen, bad_seen);
    $display("  %0d spanning trees closed, %0d results checked, %0d failures.",
             trees_closed, results_checked, fail_count);
    if (fail_count == 0)
      $display("** kruskal_union_find_edge_filter: PASSED **");
    else
      $display("** kruskal_union_find_edge_filter: FAILED **");
    $finish;
  end

endmodule
